### sv/sid_pkg.sv
// sid_pkg: shared types, widths and codes for the sorted insert deque
// no dependencies; compiled first

package sid_pkg;

	localparam int DATA_W    = 32;
	localparam int REQ_W     = 3;
	localparam int STAT_W    = 2;
	localparam int DEPTH_DEF = 16;
	localparam int CNT_W_DEF = $clog2(DEPTH_DEF + 1);

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SORTED     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic update;
		logic view;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic commit;
	} stat_t;

endpackage

### sv/sid_req_if.sv
// sid_req_if: request channel, one word per request
// depends on sid_pkg

interface sid_req_if;
	import sid_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [REQ_W-1:0]         req_type;
	logic signed [DATA_W-1:0] item_value;

	modport source (output valid, output req_type, output item_value, input ready);
	modport sink (input valid, input req_type, input item_value, output ready);
endinterface

### sv/sid_rsp_if.sv
// sid_rsp_if: result channel, one word per request
// depends on sid_pkg

interface sid_rsp_if #(
	parameter int CNT_W = sid_pkg::CNT_W_DEF
);
	import sid_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic [CNT_W-1:0]         entry_count;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;

	modport source (output valid, output status, output entry_count, output front_value,
		output back_value, input ready);
	modport sink (input valid, input status, input entry_count, input front_value,
		input back_value, output ready);
endinterface

### sv/sid_dp.sv
// sid_dp: datapath of the deque: shifting chain of value cells, fill count,
// compare flags and the result word register; depends on sid_pkg

module sid_dp #(
	parameter int DEPTH = sid_pkg::DEPTH_DEF,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sid_pkg::cmd_t                    cmd,
	output sid_pkg::stat_t                   stat,
	input  logic [sid_pkg::REQ_W-1:0]        req_type,
	input  logic signed [sid_pkg::DATA_W-1:0] item_value,
	output logic [sid_pkg::STAT_W-1:0]       status,
	output logic [CNT_W-1:0]                 entry_count,
	output logic signed [sid_pkg::DATA_W-1:0] front_value,
	output logic signed [sid_pkg::DATA_W-1:0] back_value
);
	import sid_pkg::*;

	logic signed [DATA_W-1:0] cell_q [DEPTH];
	logic [CNT_W-1:0]         count_q;

	logic [REQ_W-1:0]         req_s1;
	logic signed [DATA_W-1:0] val_s1;
	logic [DEPTH-1:0]         lt_s1;
	logic                     gt_last_s1;
	logic                     full_s1;
	logic                     empty_s1;

	logic [STAT_W-1:0]        status_q;
	logic [CNT_W-1:0]         count_out_q;
	logic signed [DATA_W-1:0] front_q;
	logic signed [DATA_W-1:0] back_q;

	logic [DEPTH-1:0]         occ;
	logic [DEPTH-1:0]         lt_c;
	logic [DEPTH-1:0]         tail;
	logic [DEPTH-1:0]         pref;
	logic [DEPTH-1:0]         mask;
	logic [DEPTH-1:0]         lastsel;
	logic signed [DATA_W-1:0] back_c;
	logic                     is_push;
	logic                     is_pop;
	logic [STAT_W-1:0]        status_c;

	// per-cell occupancy, compare and tail flags
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i]     = CNT_W'(i) < count_q;
			lt_c[i]    = occ[i] && (item_value < cell_q[i]);
			tail[i]    = CNT_W'(i) >= count_q;
			lastsel[i] = CNT_W'(i) == count_q - CNT_W'(1);
		end
	end

	// capture the request and its compare flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1     <= REQ_PUSH_FRONT;
			lt_s1      <= '0;
			gt_last_s1 <= 1'b0;
			full_s1    <= 1'b0;
			empty_s1   <= 1'b1;
		end else if (cmd.capture) begin
			req_s1     <= req_type;
			lt_s1      <= lt_c;
			gt_last_s1 <= (count_q != '0) && (item_value > back_q);
			full_s1    <= count_q == CNT_W'(DEPTH);
			empty_s1   <= count_q == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			val_s1 <= item_value;
		end
	end

	// first later cell that is strictly greater, as a thermometer
	always_comb begin
		logic acc;
		acc = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (i >= 1) begin
				acc = acc | lt_s1[i];
			end
			pref[i] = acc;
		end
	end

	// cells that move one place back on an insert
	always_comb begin
		case (req_s1)
			REQ_PUSH_FRONT: mask = '1;
			REQ_PUSH_BACK:  mask = tail;
			REQ_SORTED: begin
				if (lt_s1[0]) begin
					mask = '1;
				end else if (gt_last_s1) begin
					mask = tail;
				end else begin
					mask = pref | tail;
				end
			end
			default:        mask = '0;
		endcase
	end

	assign is_push = (req_s1 == REQ_PUSH_FRONT) || (req_s1 == REQ_PUSH_BACK) ||
		(req_s1 == REQ_SORTED);
	assign is_pop  = (req_s1 == REQ_POP_FRONT) || (req_s1 == REQ_POP_BACK);

	assign stat.commit = (is_push && !full_s1) || (is_pop && !empty_s1);

	// cell chain
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DATA_W-1:0] prev_val;
		logic signed [DATA_W-1:0] next_val;
		logic                     first;

		if (g == 0) begin : g_head
			assign prev_val = val_s1;
			assign first    = mask[0];
		end else begin : g_body
			assign prev_val = cell_q[g-1];
			assign first    = mask[g] && !mask[g-1];
		end

		if (g == DEPTH - 1) begin : g_end
			assign next_val = cell_q[g];
		end else begin : g_mid
			assign next_val = cell_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.update) begin
				if (req_s1 == REQ_POP_FRONT) begin
					cell_q[g] <= next_val;
				end else if (is_push && mask[g]) begin
					cell_q[g] <= first ? val_s1 : prev_val;
				end
			end
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.update) begin
			if (is_push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (is_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// back value through the one-hot last marker
	always_comb begin
		back_c = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (lastsel[i] && occ[i]) begin
				back_c = back_c | cell_q[i];
			end
		end
	end

	always_comb begin
		if (is_push && full_s1) begin
			status_c = ST_FULL;
		end else if (is_pop && empty_s1) begin
			status_c = ST_EMPTY;
		end else begin
			status_c = ST_DONE;
		end
	end

	// result word, also the current view of both ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= ST_DONE;
			count_out_q <= '0;
			front_q     <= '0;
			back_q      <= '0;
		end else if (cmd.view) begin
			status_q    <= status_c;
			count_out_q <= count_q;
			front_q     <= (count_q != '0) ? cell_q[0] : '0;
			back_q      <= back_c;
		end
	end

	assign status      = status_q;
	assign entry_count = count_out_q;
	assign front_value = front_q;
	assign back_value  = back_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && is_push |-> count_q != CNT_W'(DEPTH))
		else $error("insert committed on a full store");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && is_pop |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not lower the fill count");

endmodule

### sv/sid_ctrl.sv
// sid_ctrl: controller state machine of the deque; issues capture, update
// and view commands and owns both handshakes; depends on sid_pkg

module sid_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  sid_pkg::stat_t stat,
	output sid_pkg::cmd_t  cmd
);
	import sid_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_UPD  = 2'd1;
	localparam logic [1:0] S_VIEW = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	assign cmd.capture = in_valid && in_ready;
	assign cmd.update  = (state_q == S_UPD) && stat.commit;
	assign cmd.view    = (state_q == S_VIEW) && out_free;

	// next state
	always_comb begin
		case (state_q)
			S_IDLE:  state_d = cmd.capture ? S_UPD : S_IDLE;
			S_UPD:   state_d = S_VIEW;
			S_VIEW:  state_d = out_free ? S_IDLE : S_VIEW;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.view) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// checks
	a_capture_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == S_UPD)
		else $error("capture not followed by update step");

	a_upd_then_view: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |=> state_q == S_VIEW)
		else $error("update step not followed by view step");

	a_view_loads_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.view |=> out_valid_q && state_q == S_IDLE)
		else $error("view did not present a result word");

endmodule

### sv/sorted_insert_deque_unit.sv
// channel | dir | payload                                        | handshake
// req     | in  | req_type[2:0], item_value[31:0] signed         | valid/ready
// rsp     | out | status[1:0], entry_count, front_value, back_value | valid/ready
//
// each request goes through accept, cell chain update and result load in turn
// the cell chain shifts a whole row in its update step; the result word register
// sets the turn-around; a held result word delays the next load, and the
// input stays blocked until that load happens
// a new request is accepted while the previous result word still waits
// reset empties the store and clears the view to zero; no clearing pass
// depends on sid_pkg, sid_req_if, sid_rsp_if, sid_ctrl, sid_dp

module sorted_insert_deque_unit #(
	parameter int DEPTH = sid_pkg::DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	sid_req_if.sink   req,
	sid_rsp_if.source rsp
);
	import sid_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t  cmd;
	stat_t stat;

	// controller
	sid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	sid_dp #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (req.req_type),
		.item_value  (req.item_value),
		.status      (rsp.status),
		.entry_count (rsp.entry_count),
		.front_value (rsp.front_value),
		.back_value  (rsp.back_value)
	);

endmodule
